FILE: rtl/bwr_pkg.sv
// package for the bilinear warp resampler: defaults, register indexes and reset values
// used by bilinear_warp_resampler_core; depends on nothing

package bwr_pkg;

  localparam int SRC_WIDTH_DEF   = 1024;
  localparam int SRC_HEIGHT_DEF  = 1024;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int COEF_W   = 40;
  localparam int NUM_REGS = 8;
  localparam int REG_IDXW = 3;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [REG_IDXW-1:0] {
    REG_CXX = 3'd0,
    REG_CXY = 3'd1,
    REG_CXXY = 3'd2,
    REG_OFSX = 3'd3,
    REG_CYX = 3'd4,
    REG_CYY = 3'd5,
    REG_CYXY = 3'd6,
    REG_OFSY = 3'd7
  } reg_idx_t;

  localparam coef_t COEF_ONE = coef_t'(40'sd16777216);

  function automatic coef_t reg_reset_val(input reg_idx_t idx);
    coef_t val;
    case (idx)
      REG_CXX: val = COEF_ONE;
      REG_CYY: val = COEF_ONE;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/bwr_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module bwr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bilinear_warp_resampler_core.sv
// bilinear warp resampler: source frame store in four parity banks and an 8-stage pipeline
// depends on bwr_pkg and bwr_ram
//
// usage:
//   in_* stream: tuser = func (0 write pixel, 1 sample), tdata = coordinates and rgb.
//   a write stores one pixel (ignored outside the frame) and gives no result.
//   a sample maps (x, y) through the bilinear transform held in the cfg_ registers,
//   blends the four neighbours per channel and gives one out_* request.
//   cfg_ is an apb-style port, 40-bit registers at byte address 8*i; the user must write them only
//   when idle, the core does not enforce it. throughput: one request per cycle while the output
//   does not stall; out_tvalid for a sample is the 8th register stage, counting the input capture.
//   the frame is split by pixel parity into four banks so that the four neighbours
//   are read in the same cycle, one read port per bank; the pixel write uses the same stage.
//   reset clears the pipeline valid bits and reloads the coefficients (identity map);
//   the frame store content is undefined until written.
//   when a result waits and out_tready is low the whole pipeline holds; in_tready
//   follows it, nothing is lost.

module bilinear_warp_resampler_core
  import bwr_pkg::*;
#(
  parameter int SRC_WIDTH   = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT  = SRC_HEIGHT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] coord_x, [19:10] coord_y, [27:20] red_in, [35:28] green_in, [43:36] blue_in
  input  logic [47:0] in_tdata,
  // [0] func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] out_x, [19:10] out_y, [27:20] red_out, [35:28] green_out, [43:36] blue_out
  output logic [47:0] out_tdata,
  // [0] outside
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int XW = $clog2(SRC_WIDTH);
  localparam int YW = $clog2(SRC_HEIGHT);
  localparam int TW = 63;
  localparam int WB = WEIGHT_BITS;
  localparam int HALF_W = (SRC_WIDTH + 1) / 2;
  localparam int HALF_H = (SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int TOPW = 8 + WB;
  localparam int VALW = 8 + 2 * WB;

  // ---------------- configuration registers ----------------
  coef_t coef_r [NUM_REGS];
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = 64'($signed(coef_r[cfg_paddr[5:3]]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= reg_reset_val(reg_idx_t'(i));
      end
    end else if (cfg_wr) begin
      coef_r[cfg_paddr[5:3]] <= coef_t'(cfg_pwdata[COEF_W-1:0]);
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_vld_r;
  logic s1_smp_r, s2_smp_r, s3_smp_r, s4_smp_r, s5_smp_r, s6_smp_r, s7_smp_r;
  logic s1_wr_r, s2_wr_r, s3_wr_r, s4_wr_r;

  assign adv = !out_vld_r || out_tready;
  assign in_tready = adv;

  logic       in_acc;
  logic [9:0] in_x, in_y;
  logic       in_fit;

  assign in_acc = in_tvalid && adv;
  assign in_x = in_tdata[9:0];
  assign in_y = in_tdata[19:10];
  assign in_fit = (32'(in_x) < SRC_WIDTH) && (32'(in_y) < SRC_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r <= 1'b0; s2_smp_r <= 1'b0; s3_smp_r <= 1'b0; s4_smp_r <= 1'b0;
      s5_smp_r <= 1'b0; s6_smp_r <= 1'b0; s7_smp_r <= 1'b0; out_vld_r <= 1'b0;
      s1_wr_r <= 1'b0; s2_wr_r <= 1'b0; s3_wr_r <= 1'b0; s4_wr_r <= 1'b0;
    end else if (adv) begin
      s1_smp_r  <= in_acc && in_tuser;
      s1_wr_r   <= in_acc && !in_tuser && in_fit;
      s2_smp_r  <= s1_smp_r;  s2_wr_r <= s1_wr_r;
      s3_smp_r  <= s2_smp_r;  s3_wr_r <= s2_wr_r;
      s4_smp_r  <= s3_smp_r;  s4_wr_r <= s3_wr_r;
      s5_smp_r  <= s4_smp_r;
      s6_smp_r  <= s5_smp_r;
      s7_smp_r  <= s6_smp_r;
      out_vld_r <= s7_smp_r;
    end
  end

  // ---------------- stage 1: capture, x*y ----------------
  logic [9:0]  s1_x_r, s1_y_r;
  logic [19:0] s1_xy_r;
  logic [23:0] s1_rgb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r   <= in_x;
      s1_y_r   <= in_y;
      s1_xy_r  <= in_x * in_y;
      s1_rgb_r <= {in_tdata[27:20], in_tdata[35:28], in_tdata[43:36]};
    end
  end

  // ---------------- stage 2: coefficient products ----------------
  logic [9:0]  s2_x_r, s2_y_r;
  logic [23:0] s2_rgb_r;
  logic signed [50:0] s2_pxx_r, s2_pxy_r, s2_pyx_r, s2_pyy_r;
  logic signed [60:0] s2_pxxy_r, s2_pyxy_r;
  logic signed [10:0] s1_xs, s1_ys;
  logic signed [20:0] s1_xys;

  assign s1_xs  = $signed({1'b0, s1_x_r});
  assign s1_ys  = $signed({1'b0, s1_y_r});
  assign s1_xys = $signed({1'b0, s1_xy_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_rgb_r  <= s1_rgb_r;
      s2_pxx_r  <= coef_r[REG_CXX] * s1_xs;
      s2_pxy_r  <= coef_r[REG_CXY] * s1_ys;
      s2_pxxy_r <= coef_r[REG_CXXY] * s1_xys;
      s2_pyx_r  <= coef_r[REG_CYX] * s1_xs;
      s2_pyy_r  <= coef_r[REG_CYY] * s1_ys;
      s2_pyxy_r <= coef_r[REG_CYXY] * s1_xys;
    end
  end

  // ---------------- stage 3: sums ----------------
  logic [9:0]  s3_x_r, s3_y_r;
  logic [23:0] s3_rgb_r;
  logic signed [TW-1:0] s3_tx_r, s3_ty_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x_r   <= s2_x_r;
      s3_y_r   <= s2_y_r;
      s3_rgb_r <= s2_rgb_r;
      s3_tx_r  <= TW'(s2_pxx_r) + TW'(s2_pxy_r) + TW'(s2_pxxy_r) + TW'(coef_r[REG_OFSX]);
      s3_ty_r  <= TW'(s2_pyx_r) + TW'(s2_pyy_r) + TW'(s2_pyxy_r) + TW'(coef_r[REG_OFSY]);
    end
  end

  // ---------------- stage 4: floor, clamp, weights ----------------
  logic signed [TW-1:0] ipx, ipy;
  logic [FRAC_BITS+WB-1:0] fx, fy;
  logic [XW-1:0] x0_c, x1_c;
  logic [YW-1:0] y0_c, y1_c;
  logic [WB-1:0] u_c, v_c;
  logic out_c;

  always_comb begin
    ipx = s3_tx_r >>> FRAC_BITS;
    ipy = s3_ty_r >>> FRAC_BITS;
    fx = {s3_tx_r[FRAC_BITS-1:0], {WB{1'b0}}};
    fy = {s3_ty_r[FRAC_BITS-1:0], {WB{1'b0}}};
    u_c = fx[FRAC_BITS+WB-1 -: WB];
    v_c = fy[FRAC_BITS+WB-1 -: WB];
    out_c = 1'b0;
    x0_c = XW'(ipx);
    y0_c = YW'(ipy);
    if (ipx < 0) begin
      x0_c = '0; u_c = '0; out_c = 1'b1;
    end else if (ipx > $signed(TW'(SRC_WIDTH - 1))) begin
      x0_c = XW'(SRC_WIDTH - 1); u_c = '0; out_c = 1'b1;
    end
    if (ipy < 0) begin
      y0_c = '0; v_c = '0; out_c = 1'b1;
    end else if (ipy > $signed(TW'(SRC_HEIGHT - 1))) begin
      y0_c = YW'(SRC_HEIGHT - 1); v_c = '0; out_c = 1'b1;
    end
    // a write goes to its own position, all four ports point at it
    if (!s3_smp_r) begin
      x0_c = XW'(s3_x_r);
      y0_c = YW'(s3_y_r);
    end
    x1_c = (s3_smp_r && x0_c < XW'(SRC_WIDTH - 1)) ? x0_c + 1'b1 : x0_c;
    y1_c = (s3_smp_r && y0_c < YW'(SRC_HEIGHT - 1)) ? y0_c + 1'b1 : y0_c;
  end

  logic [9:0]    s4_x_r, s4_y_r;
  logic [23:0]   s4_rgb_r;
  logic [XW-1:0] s4_x0_r, s4_x1_r;
  logic [YW-1:0] s4_y0_r, s4_y1_r;
  logic [WB-1:0] s4_u_r, s4_v_r;
  logic          s4_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_x_r   <= s3_x_r;
      s4_y_r   <= s3_y_r;
      s4_rgb_r <= s3_rgb_r;
      s4_x0_r  <= x0_c;
      s4_x1_r  <= x1_c;
      s4_y0_r  <= y0_c;
      s4_y1_r  <= y1_c;
      s4_u_r   <= u_c;
      s4_v_r   <= v_c;
      s4_out_r <= out_c;
    end
  end

  // ---------------- stage 5: bank addresses ----------------
  function automatic logic [BAW-1:0] bank_addr(input logic [YW-1:0] row,
                                               input logic [XW-1:0] col);
    logic [YW:0] rh;
    logic [XW:0] chf;
    rh  = {1'b0, row} >> 1;
    chf = {1'b0, col} >> 1;
    return BAW'(rh * HALF_W + chf);
  endfunction

  logic [XW-1:0] ecol, ocol;
  logic [YW-1:0] erow, orow;

  assign ecol = s4_x0_r[0] ? s4_x1_r : s4_x0_r;
  assign ocol = s4_x0_r[0] ? s4_x0_r : s4_x1_r;
  assign erow = s4_y0_r[0] ? s4_y1_r : s4_y0_r;
  assign orow = s4_y0_r[0] ? s4_y0_r : s4_y1_r;

  logic [BAW-1:0] s5_addr_r [4];
  logic [3:0]     s5_we_r;
  logic [23:0]    s5_rgb_r;
  logic [9:0]     s5_x_r, s5_y_r;
  logic           s5_x0p_r, s5_x1p_r, s5_y0p_r, s5_y1p_r;
  logic [WB-1:0]  s5_u_r, s5_v_r;
  logic           s5_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_we_r <= '0;
    end else if (adv) begin
      for (int b = 0; b < 4; b++) begin
        s5_we_r[b] <= s4_wr_r && (2'(b) == {s4_y0_r[0], s4_x0_r[0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_addr_r[0] <= bank_addr(erow, ecol);
      s5_addr_r[1] <= bank_addr(erow, ocol);
      s5_addr_r[2] <= bank_addr(orow, ecol);
      s5_addr_r[3] <= bank_addr(orow, ocol);
      s5_rgb_r <= s4_rgb_r;
      s5_x_r   <= s4_x_r;
      s5_y_r   <= s4_y_r;
      s5_x0p_r <= s4_x0_r[0];
      s5_x1p_r <= s4_x1_r[0];
      s5_y0p_r <= s4_y0_r[0];
      s5_y1p_r <= s4_y1_r[0];
      s5_u_r   <= s4_u_r;
      s5_v_r   <= s4_v_r;
      s5_out_r <= s4_out_r;
    end
  end

  // ---------------- frame store banks, indexed {row parity, column parity} ----------------
  logic [23:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bwr_ram #(
      .WIDTH (24),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (s5_we_r[b] && adv),
      .waddr (s5_addr_r[b]),
      .wdata (s5_rgb_r),
      .re    (adv),
      .raddr (s5_addr_r[b]),
      .rdata (rd[b])
    );
  end

  // ---------------- stage 6: pixel data arrives ----------------
  logic [9:0]    s6_x_r, s6_y_r;
  logic          s6_x0p_r, s6_x1p_r, s6_y0p_r, s6_y1p_r;
  logic [WB-1:0] s6_u_r, s6_v_r;
  logic          s6_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_x_r   <= s5_x_r;
      s6_y_r   <= s5_y_r;
      s6_x0p_r <= s5_x0p_r;
      s6_x1p_r <= s5_x1p_r;
      s6_y0p_r <= s5_y0p_r;
      s6_y1p_r <= s5_y1p_r;
      s6_u_r   <= s5_u_r;
      s6_v_r   <= s5_v_r;
      s6_out_r <= s5_out_r;
    end
  end

  logic [23:0] p00, p10, p01, p11;
  logic [WB:0] u_w, inv_u;

  assign p00 = rd[{s6_y0p_r, s6_x0p_r}];
  assign p10 = rd[{s6_y0p_r, s6_x1p_r}];
  assign p01 = rd[{s6_y1p_r, s6_x0p_r}];
  assign p11 = rd[{s6_y1p_r, s6_x1p_r}];
  assign u_w = {1'b0, s6_u_r};
  assign inv_u = (WB+1)'(1 << WB) - u_w;

  // ---------------- stage 7: horizontal blend ----------------
  logic [TOPW-1:0] s7_top_r [3];
  logic [TOPW-1:0] s7_bot_r [3];
  logic [9:0]      s7_x_r, s7_y_r;
  logic [WB-1:0]   s7_v_r;
  logic            s7_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s7_top_r[c] <= TOPW'(p00[16-8*c +: 8] * inv_u) + TOPW'(p10[16-8*c +: 8] * u_w);
        s7_bot_r[c] <= TOPW'(p01[16-8*c +: 8] * inv_u) + TOPW'(p11[16-8*c +: 8] * u_w);
      end
      s7_x_r   <= s6_x_r;
      s7_y_r   <= s6_y_r;
      s7_v_r   <= s6_v_r;
      s7_out_r <= s6_out_r;
    end
  end

  // ---------------- output register: vertical blend ----------------
  logic [WB:0] v_w, inv_v;
  logic [7:0]  ch_c [3];
  logic [VALW-1:0] val_c [3];

  assign v_w = {1'b0, s7_v_r};
  assign inv_v = (WB+1)'(1 << WB) - v_w;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      val_c[c] = VALW'(s7_top_r[c] * inv_v) + VALW'(s7_bot_r[c] * v_w);
      ch_c[c] = val_c[c][2*WB +: 8];
    end
  end

  logic [9:0] o_x_r, o_y_r;
  logic [7:0] o_r_r, o_g_r, o_b_r;
  logic       o_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x_r   <= s7_x_r;
      o_y_r   <= s7_y_r;
      o_r_r   <= ch_c[0];
      o_g_r   <= ch_c[1];
      o_b_r   <= ch_c[2];
      o_out_r <= s7_out_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, o_b_r, o_g_r, o_r_r, o_y_r, o_x_r};
  assign out_tuser  = o_out_r;

endmodule

FILE: test/bilinear_warp_resampler_core_tb.sv
// testbench for bilinear_warp_resampler_core: pixel writes, warped samples, coefficient setups
// depends on bwr_pkg and the core rtl; predicts each blended pixel and checks it in order
`timescale 1ns / 1ps

module bilinear_warp_resampler_core_tb;
  import bwr_pkg::*;

  localparam int FRAME_W = 1024;
  localparam int FRAME_H = 1024;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outside;
  } warped_px_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  coef_t       warp_coef [NUM_REGS];
  logic [23:0] src_pixels [int];
  warped_px_t  pending_px [$];
  int          mismatches;
  int          cycles;
  bit          no_idle;
  int          stall_len;

  bilinear_warp_resampler_core dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long counted hold when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_len > 0) begin
      out_tready <= 1'b0;
      stall_len  <= stall_len - 1;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  // splits a fixed-point source coordinate into a clamped floor and an 8-bit weight
  function automatic int split_fixed(input longint t, input int lim, output int w,
                                     inout bit clamped);
    longint ip;
    ip = t >>> 24;
    w  = int'((t & 64'hFF_FFFF) >> 16);
    if (ip < 0) begin
      ip = 0;
      w  = 0;
      clamped = 1'b1;
    end else if (ip > lim - 1) begin
      ip = lim - 1;
      w  = 0;
      clamped = 1'b1;
    end
    return int'(ip);
  endfunction

  function automatic void locate_src(input int x, input int y, output int x0, output int x1,
                                     output int y0, output int y1, output int u,
                                     output int v, output bit clamped);
    longint xi, yi, tx, ty;
    xi = x;
    yi = y;
    tx = longint'(warp_coef[REG_CXX]) * xi + longint'(warp_coef[REG_CXY]) * yi
       + longint'(warp_coef[REG_CXXY]) * (xi * yi) + longint'(warp_coef[REG_OFSX]);
    ty = longint'(warp_coef[REG_CYX]) * xi + longint'(warp_coef[REG_CYY]) * yi
       + longint'(warp_coef[REG_CYXY]) * (xi * yi) + longint'(warp_coef[REG_OFSY]);
    clamped = 1'b0;
    x0 = split_fixed(tx, FRAME_W, u, clamped);
    y0 = split_fixed(ty, FRAME_H, v, clamped);
    x1 = (x0 < FRAME_W - 1) ? x0 + 1 : x0;
    y1 = (y0 < FRAME_H - 1) ? y0 + 1 : y0;
  endfunction

  function automatic warped_px_t blend_sample(input int x, input int y);
    warped_px_t res;
    int x0, x1, y0, y1, u, v;
    bit clamped;
    logic [23:0] p00, p10, p01, p11;
    longint top, bot, val;
    locate_src(x, y, x0, x1, y0, y1, u, v, clamped);
    p00 = src_pixels[y0 * FRAME_W + x0];
    p10 = src_pixels[y0 * FRAME_W + x1];
    p01 = src_pixels[y1 * FRAME_W + x0];
    p11 = src_pixels[y1 * FRAME_W + x1];
    res.x = x[9:0];
    res.y = y[9:0];
    res.outside = clamped;
    for (int ch = 0; ch < 3; ch++) begin
      top = longint'(p00[16-8*ch +: 8]) * (256 - u) + longint'(p10[16-8*ch +: 8]) * u;
      bot = longint'(p01[16-8*ch +: 8]) * (256 - u) + longint'(p11[16-8*ch +: 8]) * u;
      val = ((top * (256 - v) + bot * v) >> 16) & 8'hFF;
      if (ch == 0) res.red = val[7:0];
      else if (ch == 1) res.green = val[7:0];
      else res.blue = val[7:0];
    end
    return res;
  endfunction

  task automatic send_request(input bit is_sample, input int x, input int y,
                              input logic [23:0] rgb);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_sample;
    in_tdata  <= {4'b0, rgb[7:0], rgb[15:8], rgb[23:16], y[9:0], x[9:0]};
    do @(posedge clk); while (!in_tready);
    if (is_sample) pending_px = {pending_px, blend_sample(x, y)};
    else src_pixels[y * FRAME_W + x] = rgb;
  endtask

  task automatic write_pixel(input int x, input int y, input logic [23:0] rgb);
    send_request(1'b0, x, y, rgb);
  endtask

  // fills any unwritten neighbor first so no sample reads an undefined entry
  task automatic sample_pixel(input int x, input int y);
    int x0, x1, y0, y1, u, v;
    int need [4];
    bit clamped;
    locate_src(x, y, x0, x1, y0, y1, u, v, clamped);
    need = '{y0 * FRAME_W + x0, y0 * FRAME_W + x1, y1 * FRAME_W + x0, y1 * FRAME_W + x1};
    foreach (need[i])
      if (!src_pixels.exists(need[i]))
        write_pixel(need[i] % FRAME_W, need[i] / FRAME_W, 24'($urandom));
    send_request(1'b1, x, y, 24'($urandom));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    // trailing writes give no result but may still be in flight
    repeat (12) @(posedge clk);
  endtask

  task automatic set_coef(input reg_idx_t idx, input coef_t val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= 64'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    warp_coef[idx] = val;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic load_warp(input coef_t cxx, cxy, cxxy, ofsx, cyx, cyy, cyxy, ofsy);
    drain_pipeline();
    set_coef(REG_CXX, cxx);
    set_coef(REG_CXY, cxy);
    set_coef(REG_CXXY, cxxy);
    set_coef(REG_OFSX, ofsx);
    set_coef(REG_CYX, cyx);
    set_coef(REG_CYY, cyy);
    set_coef(REG_CYXY, cyxy);
    set_coef(REG_OFSY, ofsy);
  endtask

  function automatic coef_t near_coef(input longint center, input int spread);
    return coef_t'(center + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  always @(posedge clk) begin
    warped_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h / %b", out_tdata, out_tuser);
      end else begin
        want = pending_px.pop_front();
        if (out_tdata[9:0] !== want.x || out_tdata[19:10] !== want.y ||
            out_tdata[27:20] !== want.red || out_tdata[35:28] !== want.green ||
            out_tdata[43:36] !== want.blue || out_tuser !== want.outside) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at (%0d,%0d): want rgb %h %h %h out %b, got %h out %b",
                     want.x, want.y, want.red, want.green, want.blue, want.outside,
                     out_tdata, out_tuser);
        end
      end
    end
  end

  task automatic test_identity_edges();
    write_pixel(0, 0, 24'hFFFFFF);
    write_pixel(1, 0, 24'h000000);
    write_pixel(1023, 1023, 24'hFF00FF);
    write_pixel(1023, 0, 24'h00FF00);
    sample_pixel(0, 0);
    sample_pixel(1023, 1023);
    sample_pixel(1023, 0);
    sample_pixel(0, 1023);
    sample_pixel(512, 7);
  endtask

  task automatic test_fraction_blend();
    // half-pixel x shift, three-quarter-pixel y shift, with a slight shear and an xy term
    load_warp(coef_t'(40'sd16777216), coef_t'(40'sd65536), coef_t'(40'sd256),
              coef_t'(40'sd8388608), coef_t'(-40'sd65536), coef_t'(40'sd16777216),
              coef_t'(40'sd128), coef_t'(40'sd12582912));
    write_pixel(3, 3, 24'hFF0000);
    write_pixel(4, 3, 24'h00FF00);
    sample_pixel(3, 3);
    sample_pixel(0, 0);
    sample_pixel(1023, 1023);
    sample_pixel(10, 20);
    // negative offset pulls below the frame
    load_warp(coef_t'(40'sd16777216), '0, '0, coef_t'(-40'sd50331648),
              '0, coef_t'(40'sd16777216), '0, coef_t'(-40'sd1));
    sample_pixel(0, 0);
    sample_pixel(1, 5);
    sample_pixel(1023, 0);
  endtask

  task automatic test_extreme_coefs();
    coef_t cmax, cmin;
    cmax = {1'b0, {(COEF_W-1){1'b1}}};
    cmin = {1'b1, {(COEF_W-1){1'b0}}};
    load_warp(cmax, cmax, cmax, cmax, cmin, cmin, cmin, cmin);
    sample_pixel(0, 0);
    sample_pixel(1023, 1023);
    sample_pixel(1, 0);
    load_warp(cmin, cmin, cmin, cmin, cmax, cmax, cmax, cmax);
    sample_pixel(1023, 1023);
    sample_pixel(0, 1);
  endtask

  task automatic test_backpressure();
    load_warp(coef_t'(40'sd16777216), '0, '0, coef_t'(40'sd4194304),
              '0, coef_t'(40'sd16777216), '0, coef_t'(40'sd4194304));
    no_idle = 1'b1;
    stall_len = 150;
    repeat (40) sample_pixel($urandom_range(0, 31), $urandom_range(0, 31));
    no_idle = 1'b0;
  endtask

  task automatic test_random_warp();
    int x, y;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4)
        load_warp(near_coef(0, 1 << 30), near_coef(0, 1 << 30), near_coef(0, 1 << 20),
                  near_coef(0, 1 << 30), near_coef(0, 1 << 30), near_coef(0, 1 << 30),
                  near_coef(0, 1 << 20), near_coef(0, 1 << 30));
      else
        load_warp(near_coef(1 << 24, 1 << 23), near_coef(0, 1 << 21), near_coef(0, 1 << 12),
                  near_coef(0, 1 << 26), near_coef(0, 1 << 21), near_coef(1 << 24, 1 << 23),
                  near_coef(0, 1 << 12), near_coef(0, 1 << 26));
      no_idle = (phase == 2);
      for (int n = 0; n < 32; n++) begin
        if ($urandom_range(99) < 70) begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end else begin
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
        end
        if ($urandom_range(99) < 25) write_pixel(x, y, 24'($urandom));
        else sample_pixel(x, y);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cycles      = 0;
    mismatches  = 0;
    no_idle     = 1'b0;
    stall_len   = 0;
    for (int i = 0; i < NUM_REGS; i++) warp_coef[i] = reg_reset_val(reg_idx_t'(i));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_identity_edges();
    test_fraction_blend();
    test_extreme_coefs();
    test_backpressure();
    test_random_warp();
    drain_pipeline();

    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
